// ===== design/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 12;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned MAX_PAYLOAD_DEF = 2048;

  // Line codes
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;

  // Control field codes
  localparam logic [BYTE_W-1:0] CTRL_SET  = 8'h03;
  localparam logic [BYTE_W-1:0] CTRL_DISC = 8'h0B;
  localparam logic [BYTE_W-1:0] CTRL_UA   = 8'h07;
  localparam logic [BYTE_W-1:0] CTRL_RR0  = 8'h05;
  localparam logic [BYTE_W-1:0] CTRL_RR1  = 8'h85;
  localparam logic [BYTE_W-1:0] CTRL_REJ0 = 8'h01;
  localparam logic [BYTE_W-1:0] CTRL_REJ1 = 8'h81;
  localparam logic [BYTE_W-1:0] CTRL_I0   = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_I1   = 8'h40;

  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h03;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR = 1'd1;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_GOOD      = 2'd1,
    ST_CHECK_ERR = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RP_NONE  = 3'd0,
    RP_UA    = 3'd1,
    RP_DISC  = 3'd2,
    RP_RR0   = 3'd3,
    RP_RR1   = 3'd4,
    RP_DATA0 = 3'd5,
    RP_DATA1 = 3'd6
  } reply_t;

  typedef struct packed {
    logic                 is_frame_end;
    logic [BYTE_W-1:0]    payload_byte;
    logic [BYTE_W-1:0]    control_code;
    status_t              frame_status;
    reply_t               reply_action;
    logic [LEN_W-1:0]     payload_length;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    data;
  } cfg_wr_t;

endpackage

// ===== design/sfr_rx_if.sv =====
`timescale 1ns / 1ps

interface sfr_rx_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/sfr_res_if.sv =====
`timescale 1ns / 1ps

interface sfr_res_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_frame_end;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] control_code;
  logic [1:0]        frame_status;
  logic [2:0]        reply_action;
  logic [LEN_W-1:0]  payload_length;

  modport source (output valid, output is_frame_end, output payload_byte,
                  output control_code, output frame_status, output reply_action,
                  output payload_length, input ready);
  modport sink   (input valid, input is_frame_end, input payload_byte,
                  input control_code, input frame_status, input reply_action,
                  input payload_length, output ready);
endinterface

// ===== design/sfr_cfg_if.sv =====
`timescale 1ns / 1ps

interface sfr_cfg_if import sfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [BYTE_W-1:0]    reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== design/sfr_core.sv =====
`timescale 1ns / 1ps

module sfr_core import sfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_wr_t           cfg_wr,
  input  logic              beat,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              emit,
  output result_t           res
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_FLAG = 3'd1,
    PH_ADDR = 3'd2,
    PH_CTRL = 3'd3,
    PH_BODY = 3'd4,
    PH_DROP = 3'd5
  } phase_t;

  logic              role_is_sender;
  logic [BYTE_W-1:0] address_byte;

  phase_t            phase,       phase_next;
  logic              esc_pending, esc_pending_next;
  logic [BYTE_W-1:0] frame_ctrl,  frame_ctrl_next;
  logic [BYTE_W-1:0] held_byte,   held_byte_next;
  logic              held_valid,  held_valid_next;
  logic [BYTE_W-1:0] run_xor,     run_xor_next;
  logic [CNT_W-1:0]  byte_count,  byte_count_next;

  function automatic logic ctrl_ok(input logic sender, input logic [BYTE_W-1:0] c);
    logic ok;
    ok = 1'b0;
    if (sender) begin
      case (c) inside
        CTRL_UA, CTRL_RR0, CTRL_RR1, CTRL_DISC, CTRL_REJ0, CTRL_REJ1: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end else begin
      case (c) inside
        CTRL_SET, CTRL_DISC, CTRL_I0, CTRL_I1: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  function automatic reply_t reply_for(input logic sender, input logic [BYTE_W-1:0] c);
    reply_t r;
    r = RP_NONE;
    if (sender) begin
      case (c) inside
        CTRL_RR0, CTRL_REJ0: r = RP_DATA0;
        CTRL_RR1, CTRL_REJ1: r = RP_DATA1;
        CTRL_DISC:           r = RP_UA;
        default:             r = RP_NONE;
      endcase
    end else begin
      case (c)
        CTRL_SET:  r = RP_UA;
        CTRL_DISC: r = RP_DISC;
        CTRL_I0:   r = RP_RR1;
        CTRL_I1:   r = RP_RR0;
        default:   r = RP_NONE;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    status_t st;
    phase_next       = phase;
    esc_pending_next = esc_pending;
    frame_ctrl_next  = frame_ctrl;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    run_xor_next     = run_xor;
    byte_count_next  = byte_count;
    emit             = 1'b0;
    st               = ST_EMPTY;
    res              = '0;
    res.control_code = frame_ctrl;

    unique case (phase)
      PH_FLAG: begin
        if (rx_byte == address_byte) begin
          phase_next = PH_ADDR;
        end else if (rx_byte != FLAG_BYTE) begin
          phase_next = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (ctrl_ok(role_is_sender, rx_byte)) begin
          frame_ctrl_next = rx_byte;
          phase_next      = PH_CTRL;
        end else begin
          phase_next = (rx_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx_byte == FLAG_BYTE) begin
          phase_next = PH_FLAG;
        end else if (rx_byte == (address_byte ^ frame_ctrl)) begin
          phase_next       = PH_BODY;
          esc_pending_next = 1'b0;
          held_valid_next  = 1'b0;
          run_xor_next     = '0;
          byte_count_next  = '0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY, PH_DROP: begin
        if (!esc_pending && rx_byte == FLAG_BYTE) begin
          // closing flag doubles as the next opening flag
          if (phase == PH_DROP) begin
            st = ST_OVERFLOW;
          end else if (!held_valid) begin
            st = ST_EMPTY;
          end else begin
            st = (held_byte == run_xor) ? ST_GOOD : ST_CHECK_ERR;
          end
          emit               = 1'b1;
          res.is_frame_end   = 1'b1;
          res.frame_status   = st;
          res.reply_action   = (st == ST_EMPTY || st == ST_GOOD) ?
                               reply_for(role_is_sender, frame_ctrl) : RP_NONE;
          res.payload_length = LEN_W'(byte_count);
          phase_next         = PH_FLAG;
          esc_pending_next   = 1'b0;
          held_valid_next    = 1'b0;
        end else if (!esc_pending && rx_byte == ESC_BYTE) begin
          esc_pending_next = 1'b1;
        end else begin
          esc_pending_next = 1'b0;
          if (phase == PH_BODY) begin
            if (!held_valid) begin
              held_byte_next  = rx_byte;
              held_valid_next = 1'b1;
            end else if (byte_count >= CNT_MAX) begin
              phase_next      = PH_DROP;
              held_valid_next = 1'b0;
            end else begin
              // release the held byte, keep the newest one back as check byte
              emit             = 1'b1;
              res.payload_byte = held_byte;
              run_xor_next     = run_xor ^ held_byte;
              byte_count_next  = byte_count + CNT_W'(1);
              held_byte_next   = rx_byte;
            end
          end
        end
      end
      default: begin
        phase_next = (rx_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      role_is_sender <= 1'b0;
      address_byte   <= ADDR_RESET;
      phase          <= PH_HUNT;
      esc_pending    <= 1'b0;
      held_valid     <= 1'b0;
    end else begin
      if (cfg_wr.we) begin
        unique case (cfg_wr.idx)
          REG_ROLE: role_is_sender <= cfg_wr.data[0];
          REG_ADDR: address_byte   <= cfg_wr.data;
          default:  ;
        endcase
      end
      if (beat) begin
        phase       <= phase_next;
        esc_pending <= esc_pending_next;
        held_valid  <= held_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      frame_ctrl <= frame_ctrl_next;
      held_byte  <= held_byte_next;
      run_xor    <= run_xor_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

// ===== design/sfr_out_reg.sv =====
`timescale 1ns / 1ps

module sfr_out_reg import sfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    space,
  output logic    out_valid,
  output result_t res_out
);

  logic full;

  // take a new beat when empty, or while the held result leaves in the same cycle
  assign space     = !full || out_ready;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== design/stuffed_frame_receiver.sv =====
`timescale 1ns / 1ps

// Channel   Role   Beat carries
// rx        sink   rx_byte: one raw line byte
// result    source payload byte or end-of-frame record (status, reply, length)
// cfg       sink   reg_index 0 role_is_sender, 1 address_byte; reg_data
//
// One line byte is taken every cycle while rx.ready is high; its result, if any,
// is in the output register in the cycle after the beat. The byte decode is a
// single pass from the frame state registers to that output register.
// rx.ready drops only while a result is held and result.ready is low.
// rst clears the frame state, the output register and both registers to
// their defaults (receiver role, address 0x03). cfg is always ready.

module stuffed_frame_receiver import sfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic     clk,
  input  logic     rst,
  sfr_rx_if.sink   rx,
  sfr_res_if.source result,
  sfr_cfg_if.sink  cfg
);

  logic    space;
  logic    beat;
  logic    emit;
  logic    out_valid;
  result_t core_res;
  result_t out_res;
  cfg_wr_t cfg_wr;

  assign rx.ready  = space;
  assign beat      = rx.valid && space;
  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_wr.we   = cfg.valid;
    cfg_wr.idx  = cfg.reg_index;
    cfg_wr.data = cfg.reg_data;
  end

  sfr_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg_wr  (cfg_wr),
    .beat    (beat),
    .rx_byte (rx.rx_byte),
    .emit    (emit),
    .res     (core_res)
  );

  sfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (beat && emit),
    .res_in    (core_res),
    .out_ready (result.ready),
    .space     (space),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign result.valid          = out_valid;
  assign result.is_frame_end   = out_res.is_frame_end;
  assign result.payload_byte   = out_res.payload_byte;
  assign result.control_code   = out_res.control_code;
  assign result.frame_status   = out_res.frame_status;
  assign result.reply_action   = out_res.reply_action;
  assign result.payload_length = out_res.payload_length;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sfr_pkg::*;

  typedef logic [BYTE_W-1:0] line_byte_t;

  typedef enum logic [2:0] {
    LK_HUNT, LK_FLAG, LK_ADDR, LK_CTRL, LK_BODY, LK_DROP
  } link_phase_t;

  typedef enum int {
    FAULT_NONE, FAULT_ADDR, FAULT_FLAG, FAULT_HCS, FAULT_FCS
  } frame_fault_t;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 4;
  localparam int END_SETTLE   = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_BYTES = 1850;
  localparam int PHASES       = 6;

  logic clk;
  logic rst;

  sfr_rx_if  rx_ch ();
  sfr_res_if res_ch ();
  sfr_cfg_if cfg_ch ();

  stuffed_frame_receiver i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // link decoder mirror
  bit          role_sender  = 1'b0;
  line_byte_t  station_addr = ADDR_RESET;
  link_phase_t link_phase   = LK_HUNT;
  bit          esc_seen     = 1'b0;
  line_byte_t  cur_ctrl     = '0;
  line_byte_t  lag_byte     = '0;
  bit          lag_full     = 1'b0;
  line_byte_t  pay_xor      = '0;
  int          pay_count    = 0;

  result_t    decoded_q[$];
  line_byte_t line_q[$];

  int mismatches  = 0;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit calm        = 1'b0;
  bit tx_bursty   = 1'b1;
  bit hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit ctrl_ok(input line_byte_t c);
    if (role_sender)
      return c == CTRL_UA || c == CTRL_RR0 || c == CTRL_RR1 || c == CTRL_DISC ||
             c == CTRL_REJ0 || c == CTRL_REJ1;
    return c == CTRL_SET || c == CTRL_DISC || c == CTRL_I0 || c == CTRL_I1;
  endfunction

  function automatic reply_t reply_of(input line_byte_t c);
    if (role_sender) begin
      case (c)
        CTRL_RR0, CTRL_REJ0: return RP_DATA0;
        CTRL_RR1, CTRL_REJ1: return RP_DATA1;
        CTRL_DISC:           return RP_UA;
        default:             return RP_NONE;
      endcase
    end
    case (c)
      CTRL_SET:  return RP_UA;
      CTRL_DISC: return RP_DISC;
      CTRL_I0:   return RP_RR1;
      CTRL_I1:   return RP_RR0;
      default:   return RP_NONE;
    endcase
  endfunction

  // Advance the mirror by one line byte; returns 1 when a beat is due.
  function automatic bit decode_line_byte(input line_byte_t b, output result_t r);
    bit      emit;
    status_t st;
    emit = 1'b0;
    r = '0;
    case (link_phase)
      LK_FLAG: begin
        // address match wins over the flag test
        if (b == station_addr) link_phase = LK_ADDR;
        else if (b != FLAG_BYTE) link_phase = LK_HUNT;
      end
      LK_ADDR: begin
        if (ctrl_ok(b)) begin
          cur_ctrl = b;
          link_phase = LK_CTRL;
        end else begin
          link_phase = (b == FLAG_BYTE) ? LK_FLAG : LK_HUNT;
        end
      end
      LK_CTRL: begin
        if (b == FLAG_BYTE) begin
          link_phase = LK_FLAG;
        end else if (b == (station_addr ^ cur_ctrl)) begin
          link_phase = LK_BODY;
          esc_seen = 1'b0;
          lag_byte = '0;
          lag_full = 1'b0;
          pay_xor = '0;
          pay_count = 0;
        end else begin
          link_phase = LK_HUNT;
        end
      end
      LK_BODY, LK_DROP: begin
        if (!esc_seen && b == FLAG_BYTE) begin
          if (link_phase == LK_DROP) st = ST_OVERFLOW;
          else if (!lag_full) st = ST_EMPTY;
          else st = (lag_byte == pay_xor) ? ST_GOOD : ST_CHECK_ERR;
          r.is_frame_end = 1'b1;
          r.control_code = cur_ctrl;
          r.frame_status = st;
          r.reply_action = (st == ST_EMPTY || st == ST_GOOD) ? reply_of(cur_ctrl) : RP_NONE;
          r.payload_length = LEN_W'(pay_count);
          link_phase = LK_FLAG;
          esc_seen = 1'b0;
          lag_full = 1'b0;
          emit = 1'b1;
        end else if (!esc_seen && b == ESC_BYTE) begin
          esc_seen = 1'b1;
        end else begin
          esc_seen = 1'b0;
          if (link_phase == LK_DROP) begin
            // discard up to the closing flag
          end else if (!lag_full) begin
            lag_byte = b;
            lag_full = 1'b1;
          end else if (pay_count >= MAX_PAYLOAD_DEF) begin
            link_phase = LK_DROP;
            lag_full = 1'b0;
          end else begin
            r.payload_byte = lag_byte;
            r.control_code = cur_ctrl;
            pay_xor = pay_xor ^ lag_byte;
            pay_count++;
            lag_byte = b;
            emit = 1'b1;
          end
        end
      end
      default: link_phase = (b == FLAG_BYTE) ? LK_FLAG : LK_HUNT;
    endcase
    return emit;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_beat
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = decoded_q.pop_front();
        if (res_ch.is_frame_end !== want.is_frame_end)
          flag_mismatch($sformatf("is_frame_end got %0d want %0d",
                                  res_ch.is_frame_end, want.is_frame_end));
        if (res_ch.payload_byte !== want.payload_byte)
          flag_mismatch($sformatf("payload_byte got %0h want %0h",
                                  res_ch.payload_byte, want.payload_byte));
        if (res_ch.control_code !== want.control_code)
          flag_mismatch($sformatf("control_code got %0h want %0h",
                                  res_ch.control_code, want.control_code));
        if (res_ch.frame_status !== want.frame_status)
          flag_mismatch($sformatf("frame_status got %0d want %0d",
                                  res_ch.frame_status, want.frame_status));
        if (res_ch.reply_action !== want.reply_action)
          flag_mismatch($sformatf("reply_action got %0d want %0d",
                                  res_ch.reply_action, want.reply_action));
        if (res_ch.payload_length !== want.payload_length)
          flag_mismatch($sformatf("payload_length got %0d want %0d",
                                  res_ch.payload_length, want.payload_length));
      end
    end
  end

  // result.ready: random stall bursts, quiet stretches, one long hold-off
  initial begin : drive_res_ready
    int stall_left;
    int hold_left;
    int mode_left;
    bit bursty;
    res_ch.ready = 1'b0;
    stall_left = 0;
    hold_left = 0;
    mode_left = 0;
    bursty = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(40, 300);
        bursty = $urandom_range(0, 3) != 0;
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!calm && bursty && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Call at a rising edge; returns at the edge that took the beat (or after a gap).
  task automatic send_byte(input line_byte_t b);
    result_t next_res;
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    if (decode_line_byte(b, next_res)) decoded_q.push_back(next_res);
    if (!calm && tx_bursty && $urandom_range(0, 4) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic drain_and_settle(input int settle);
    rx_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write both registers; call only while the block is idle.
  task automatic set_link(input bit role, input line_byte_t addr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= REG_ROLE;
    cfg_ch.reg_data <= {7'($urandom_range(0, 127)), role};
    do @(posedge clk); while (!cfg_ch.ready);
    role_sender = role;
    cfg_ch.reg_index <= REG_ADDR;
    cfg_ch.reg_data <= addr;
    do @(posedge clk); while (!cfg_ch.ready);
    station_addr = addr;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic line_byte_t pick_ctrl();
    if ($urandom_range(0, 7) == 0) return line_byte_t'($urandom_range(0, 255));
    if (role_sender) begin
      case ($urandom_range(0, 5))
        0:       return CTRL_UA;
        1:       return CTRL_RR0;
        2:       return CTRL_RR1;
        3:       return CTRL_DISC;
        4:       return CTRL_REJ0;
        default: return CTRL_REJ1;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return CTRL_SET;
      1:       return CTRL_DISC;
      2:       return CTRL_I0;
      default: return CTRL_I1;
    endcase
  endfunction

  function automatic line_byte_t pick_payload();
    case ($urandom_range(0, 9))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return line_byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Escape flag and escape bytes, plus the odd ordinary byte.
  function automatic void stuff_byte(input line_byte_t b);
    if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0)
      line_q.push_back(ESC_BYTE);
    line_q.push_back(b);
  endfunction

  task automatic send_frame(input line_byte_t ctrl, input int plen,
                            input frame_fault_t fault, input bit close);
    line_byte_t fcs;
    line_byte_t pb;
    line_byte_t hcs;
    line_q.delete();
    fcs = '0;
    hcs = station_addr ^ ctrl;
    // skipping the opening flag leans on the previous closing flag
    if (plen > 40 || $urandom_range(0, 3) != 0) line_q.push_back(FLAG_BYTE);
    if (fault == FAULT_FLAG) begin
      line_q.push_back(station_addr);
      if ($urandom_range(0, 1)) line_q.push_back(ctrl);
      line_q.push_back(FLAG_BYTE);
    end
    if (fault == FAULT_ADDR)
      line_q.push_back(station_addr ^ (8'h01 << $urandom_range(0, 7)));
    else
      line_q.push_back(station_addr);
    line_q.push_back(ctrl);
    if (fault == FAULT_HCS) line_q.push_back(hcs ^ 8'(1 + $urandom_range(0, 254)));
    else line_q.push_back(hcs);
    for (int i = 0; i < plen; i++) begin
      pb = pick_payload();
      fcs = fcs ^ pb;
      stuff_byte(pb);
    end
    if (close) begin
      if (fault == FAULT_FCS) stuff_byte(fcs ^ 8'(1 + $urandom_range(0, 254)));
      else if (plen != 0 || $urandom_range(0, 2) != 0) stuff_byte(fcs);
      line_q.push_back(FLAG_BYTE);
    end
    send_line();
  endtask

  task automatic send_noise(input int n);
    line_q.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0, 1:    line_q.push_back(FLAG_BYTE);
        2:       line_q.push_back(ESC_BYTE);
        3:       line_q.push_back(station_addr);
        default: line_q.push_back(line_byte_t'($urandom_range(0, 255)));
      endcase
    end
    send_line();
  endtask

  task automatic test_directed();
    // empty frame, lone zero check byte over a shared flag, escaped flag
    // as data, flag in the control position followed by a bad check byte
    line_q = '{FLAG_BYTE, ADDR_RESET, CTRL_SET, ADDR_RESET ^ CTRL_SET, FLAG_BYTE,
               ADDR_RESET, CTRL_I0, ADDR_RESET ^ CTRL_I0, 8'h00, FLAG_BYTE,
               ADDR_RESET, CTRL_I1, ADDR_RESET ^ CTRL_I1, ESC_BYTE, FLAG_BYTE, 8'hFF,
               FLAG_BYTE ^ 8'hFF, FLAG_BYTE,
               ADDR_RESET, FLAG_BYTE, ADDR_RESET, CTRL_DISC, ADDR_RESET ^ CTRL_DISC,
               8'h55, FLAG_BYTE};
    send_line();
  endtask

  task automatic test_backpressure();
    drain_and_settle(SETTLE);
    tx_bursty = 1'b0;
    hold_req = 1'b1;
    send_frame(CTRL_SET, 60, FAULT_NONE, 1'b1);
    // hold the line until every beat is back
    drain_and_settle(SETTLE);
    tx_bursty = 1'b1;
  endtask

  task automatic test_overflow();
    drain_and_settle(SETTLE);
    set_link(1'b1, 8'hFF);
    send_frame(CTRL_RR1, MAX_PAYLOAD_DEF, FAULT_NONE, 1'b1);
    send_frame(CTRL_DISC, MAX_PAYLOAD_DEF + 4, FAULT_NONE, 1'b1);
  endtask

  task automatic test_random();
    line_byte_t   addr;
    frame_fault_t fault;
    int           plen;
    int           stop_at;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle(SETTLE);
      case (ph)
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        2:       addr = FLAG_BYTE;
        3:       addr = ESC_BYTE;
        4:       addr = ADDR_RESET;
        default: addr = line_byte_t'($urandom_range(0, 255));
      endcase
      set_link(ph[0] ^ ph[2], addr);
      stop_at = bytes_sent + RANDOM_BYTES / PHASES;
      while (bytes_sent < stop_at) begin
        tx_bursty = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 4) == 0) begin
          send_noise($urandom_range(1, 8));
        end else begin
          plen = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
          fault = ($urandom_range(0, 3) == 0) ? frame_fault_t'($urandom_range(1, 4))
                                                : FAULT_NONE;
          send_frame(pick_ctrl(), plen, fault, 1'b1);
        end
      end
      // leave a frame open across the next register change now and then
      if ($urandom_range(0, 1)) send_frame(pick_ctrl(), $urandom_range(0, 3), FAULT_NONE, 1'b0);
    end
  endtask

  task automatic test_calm_tail();
    drain_and_settle(SETTLE);
    set_link(1'($urandom_range(0, 1)), line_byte_t'($urandom_range(0, 255)));
    calm = 1'b1;
    repeat (10) send_frame(pick_ctrl(), $urandom_range(0, 12), FAULT_NONE, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.reg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_overflow();
    test_random();
    test_calm_tail();
    drain_and_settle(END_SETTLE);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/sfr_pkg.sv
design/sfr_rx_if.sv
design/sfr_res_if.sv
design/sfr_cfg_if.sv
design/sfr_core.sv
design/sfr_out_reg.sv
design/stuffed_frame_receiver.sv
tb/sv/tb_top.sv
